// ===== rtl/bmpdc_pkg.sv =====
package bmpdc_pkg;

   // Header byte positions (little-endian width, then height)
   localparam logic [31:0] HDR_W_LO = 32'd18;
   localparam logic [31:0] HDR_W_HI = 32'd21;
   localparam logic [31:0] HDR_H_LO = 32'd22;
   localparam logic [31:0] HDR_H_HI = 32'd25;

   // Pixel data may not start inside the header
   localparam logic [11:0] MIN_OFFSET     = 12'd26;
   localparam logic [11:0] DEFAULT_OFFSET = 12'd54;

   localparam int BYTES_PER_PIXEL = 3;

   // Pixel component sequence within one triple
   typedef enum logic [1:0] {
      COMP_BLUE  = 2'd0,
      COMP_GREEN = 2'd1,
      COMP_RED   = 2'd2
   } comp_type;

   // One byte's transaction as it travels down the color cell chain
   typedef struct packed {
      logic        live;       // slot holds a transaction
      logic        clear;      // first byte of a new file: empties the set
      logic        pixel;      // this byte completed a pixel
      logic [23:0] color;      // red, green, blue
      logic        hit;        // color already found in an earlier cell
      logic        placed;     // color stored in a free cell
      logic        hdr_valid;
      logic        hdr_err;
      logic [31:0] width;
      logic [31:0] height;
   } tok_type;

endpackage

// ===== rtl/bmpdc_if.sv =====
// Byte input channel
interface bmpdc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;

   modport source(output valid, data_byte, first_byte, input ready);
   modport sink(input valid, data_byte, first_byte, output ready);
endinterface

// Status result channel
interface bmpdc_rsp_if;
   logic        valid;
   logic        ready;
   logic        header_valid;
   logic [31:0] image_width;
   logic [31:0] image_height;
   logic        header_error;
   logic        new_color;
   logic [23:0] color_value;
   logic [7:0]  color_index;
   logic [8:0]  distinct_count;
   logic        table_full;

   modport source(output valid, header_valid, image_width, image_height, header_error,
                  new_color, color_value, color_index, distinct_count, table_full,
                  input ready);
   modport sink(input valid, header_valid, image_width, image_height, header_error,
                new_color, color_value, color_index, distinct_count, table_full,
                output ready);
endinterface

// Pixel data offset register write channel
interface bmpdc_csr_if;
   logic        valid;
   logic        ready;
   logic [11:0] pixel_data_offset;

   modport source(output valid, pixel_data_offset, input ready);
   modport sink(input valid, pixel_data_offset, output ready);
endinterface

// ===== rtl/bmpdc_parser.sv =====
module bmpdc_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              first_byte,
   input  logic [11:0]       offset,
   output bmpdc_pkg::tok_type tok
);
   import bmpdc_pkg::*;

   logic [31:0] pos_ff, pos_in, pos_eff;
   logic [31:0] width_ff, width_in, width_eff;
   logic [31:0] height_ff, height_in, height_eff;
   logic [33:0] row_ff, row_in, row_eff, row_inc;
   comp_type    comp_ff, comp_in, comp_eff;
   logic [15:0] part_ff, part_in, part_eff;
   logic [33:0] data_len, stride;
   logic [11:0] offset_eff;
   logic        hdr_valid, hdr_err, in_pix, pix_done;

   // A first byte restarts the file before the byte itself is handled
   assign pos_eff    = first_byte ? '0 : pos_ff;
   assign width_eff  = first_byte ? '0 : width_ff;
   assign height_eff = first_byte ? '0 : height_ff;
   assign row_eff    = first_byte ? '0 : row_ff;
   assign comp_eff   = first_byte ? COMP_BLUE : comp_ff;
   assign part_eff   = first_byte ? '0 : part_ff;

   // Header field assembly, one byte lane per position
   always_comb begin
      width_in  = width_eff;
      height_in = height_eff;
      for (int k = 0; k < 4; k++) begin
         if (pos_eff == HDR_W_LO + 32'(k)) width_in[8*k +: 8]  = width_eff[8*k +: 8] | data_byte;
         if (pos_eff == HDR_H_LO + 32'(k)) height_in[8*k +: 8] = height_eff[8*k +: 8] | data_byte;
      end
   end

   assign hdr_valid = pos_eff >= HDR_H_HI;
   assign hdr_err   = hdr_valid && (width_in == '0) && (height_in == '0);

   // Row geometry: width*3 data bytes, padded to a multiple of four
   assign data_len   = {2'b00, width_in} + {1'b0, width_in, 1'b0};
   assign stride     = (data_len + 34'd3) & ~34'd3;
   assign offset_eff = (offset < MIN_OFFSET) ? MIN_OFFSET : offset;
   assign in_pix     = hdr_valid && !hdr_err && (pos_eff >= {20'd0, offset_eff})
                       && (width_in != '0);
   assign row_inc    = row_eff + 34'd1;

   // Row position and pixel component grouping
   always_comb begin
      row_in   = row_eff;
      comp_in  = comp_eff;
      part_in  = part_eff;
      pix_done = 1'b0;
      if (in_pix) begin
         if (row_eff < data_len) begin
            case (comp_eff)
               COMP_BLUE: begin
                  part_in = {8'd0, data_byte};
                  comp_in = COMP_GREEN;
               end
               COMP_GREEN: begin
                  part_in = {data_byte, part_eff[7:0]};
                  comp_in = COMP_RED;
               end
               default: begin
                  pix_done = 1'b1;
                  part_in  = '0;
                  comp_in  = COMP_BLUE;
               end
            endcase
         end
         row_in = (row_inc >= stride) ? '0 : row_inc;
      end
   end

   // Saturating byte position
   assign pos_in = (pos_eff == '1) ? pos_eff : pos_eff + 32'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         row_ff    <= '0;
         comp_ff   <= COMP_BLUE;
         part_ff   <= '0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         row_ff    <= row_in;
         comp_ff   <= comp_in;
         part_ff   <= part_in;
      end
   end

   // Transaction handed to the first cell
   always_comb begin
      tok.live      = accept;
      tok.clear     = first_byte;
      tok.pixel     = pix_done;
      tok.color     = pix_done ? {data_byte, part_eff} : '0;
      tok.hit       = 1'b0;
      tok.placed    = 1'b0;
      tok.hdr_valid = hdr_valid;
      tok.hdr_err   = hdr_err;
      tok.width     = width_in;
      tok.height    = height_in;
   end

endmodule

// ===== rtl/bmpdc_cell.sv =====
module bmpdc_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  bmpdc_pkg::tok_type tok_in,
   output bmpdc_pkg::tok_type tok_out
);
   import bmpdc_pkg::*;

   logic                       occ_ff, occ_in, occ_eff;
   logic [23:0]                color_ff, color_in;
   logic                       live_ff;
   logic [$bits(tok_type)-2:0] pay_ff;
   tok_type                    tok_in_mod;
   logic                       search;

   // A clearing transaction empties this slot before it is probed
   assign occ_eff = (tok_in.live && tok_in.clear) ? 1'b0 : occ_ff;
   assign search  = tok_in.live && tok_in.pixel && !tok_in.hit && !tok_in.placed;

   // Compare against the stored color, or claim the slot when free
   always_comb begin
      tok_in_mod = tok_in;
      occ_in     = occ_eff;
      color_in   = color_ff;
      if (search) begin
         if (occ_eff) begin
            tok_in_mod.hit = (color_ff == tok_in.color);
         end else begin
            occ_in            = 1'b1;
            color_in          = tok_in.color;
            tok_in_mod.placed = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff  <= 1'b0;
         live_ff <= 1'b0;
      end else if (adv) begin
         occ_ff  <= occ_in;
         live_ff <= tok_in.live;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (adv) begin
         color_ff <= color_in;
         pay_ff   <= tok_in_mod[$bits(tok_type)-2:0];
      end
   end

   assign tok_out = {live_ff, pay_ff};

endmodule

// ===== rtl/bmp24_distinct_color_collector.sv =====
// Distinct color collector for a 24-bit BMP byte stream.
// req_chan takes one file byte per transaction; first_byte marks byte 0 of
// a new file and restarts position, header and color set. rsp_chan returns
// one status transaction per byte, in order: header fields, header error,
// the completed pixel color, new-color flag with its slot, the distinct
// count and the set-full flag. csr_chan writes pixel_data_offset; a write
// applies from the next byte and should be made only while no bytes are
// in flight.
// The color set is a row of MAX_COLORS cells. Each byte's transaction
// moves one cell per cycle while the chain advances; a completed pixel is
// compared in each cell and stored in the first free one, so one byte is
// taken every cycle unless rsp_chan stalls; the response is registered.
// When rsp_chan stalls the whole chain holds and req_chan.ready drops;
// nothing is lost. Reset empties the set, clears the header state and
// the response register, and restores the offset to 54.
module bmp24_distinct_color_collector #(
   parameter int MAX_COLORS = 256
) (
   input logic       clock,
   input logic       reset,
   bmpdc_req_if.sink   req_chan,
   bmpdc_rsp_if.source rsp_chan,
   bmpdc_csr_if.sink   csr_chan
);
   import bmpdc_pkg::*;

   localparam int CW = $clog2(MAX_COLORS + 1);

   logic        adv, accept;
   logic [11:0] offset_ff;
   tok_type     chain [0:MAX_COLORS];
   tok_type     tail;
   logic [CW-1:0] cnt_ff, cnt_in, cnt_eff;

   logic        rsp_valid_ff;
   logic        hdr_valid_ff, hdr_err_ff, new_ff, full_ff;
   logic [31:0] width_ff, height_ff;
   logic [23:0] color_ff;
   logic [7:0]  index_ff;
   logic [8:0]  count_ff;

   // Chain advances whenever the response register can take a transaction
   assign adv            = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign accept         = req_chan.valid && adv;

   // Offset register
   assign csr_chan.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= DEFAULT_OFFSET;
      end else if (csr_chan.valid) begin
         offset_ff <= csr_chan.pixel_data_offset;
      end
   end

   bmpdc_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_chan.data_byte),
      .first_byte (req_chan.first_byte),
      .offset     (offset_ff),
      .tok        (chain[0])
   );

   // Row of color cells
   for (genvar i = 0; i < MAX_COLORS; i++) begin : g_cell
      bmpdc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .tok_in  (chain[i]),
         .tok_out (chain[i+1])
      );
   end

   assign tail = chain[MAX_COLORS];

   // Distinct count follows the cells, which fill in slot order
   assign cnt_eff = tail.clear ? '0 : cnt_ff;
   assign cnt_in  = cnt_eff + CW'(tail.placed);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= tail.live;
         if (tail.live) cnt_ff <= cnt_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (adv && tail.live) begin
         hdr_valid_ff <= tail.hdr_valid;
         hdr_err_ff   <= tail.hdr_err;
         width_ff     <= tail.width;
         height_ff    <= tail.height;
         new_ff       <= tail.placed;
         color_ff     <= tail.color;
         index_ff     <= tail.placed ? 8'(cnt_eff) : 8'd0;
         count_ff     <= 9'(cnt_in);
         full_ff      <= tail.pixel && !tail.hit && !tail.placed;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.header_valid   = hdr_valid_ff;
   assign rsp_chan.image_width    = width_ff;
   assign rsp_chan.image_height   = height_ff;
   assign rsp_chan.header_error   = hdr_err_ff;
   assign rsp_chan.new_color      = new_ff;
   assign rsp_chan.color_value    = color_ff;
   assign rsp_chan.color_index    = index_ff;
   assign rsp_chan.distinct_count = count_ff;
   assign rsp_chan.table_full     = full_ff;

   // Count never passes the number of cells
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_COLORS))
      else $error("distinct count exceeds set capacity");

   // A color is either stored or dropped, never both
   a_new_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(new_ff && full_ff))
      else $error("new color and set full flagged together");

   // A stored color takes the slot just below the new count
   a_index_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && new_ff) |->
         ((MAX_COLORS > 256) || (count_ff == {1'b0, index_ff} + 9'd1)))
      else $error("color index does not match distinct count");

   // A transaction leaving the chain never both matched and claimed a slot
   a_hit_place: assert property (@(posedge clock) disable iff (reset)
      tail.live |-> !(tail.hit && tail.placed))
      else $error("pixel both matched and stored");

endmodule
